>>> hw/rtl/ppmf_pkg.sv
// shared types, constants and address helpers for the page packed framebuffer
// no dependencies

package ppmf_pkg;

  localparam int COLUMNS    = 128;
  localparam int ROWS       = 32;
  localparam int GLYPH_ROWS = 7;
  localparam int PAGES      = (ROWS + 7) / 8;
  localparam int STORE_SIZE = PAGES * COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int DATA_W     = 8;
  localparam int PAGE_W     = 2;
  localparam int COL_W      = 7;

  localparam logic [DATA_W-1:0] GLYPH_MASK = DATA_W'((1 << GLYPH_ROWS) - 1);

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_GLYPH = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [DATA_W-1:0] pixel_byte;
    logic [PAGE_W-1:0] byte_page;
    logic [COL_W-1:0]  byte_column;
  } result_t;

  // rows of a page byte that lie on the screen
  function automatic logic [DATA_W-1:0] row_ok(logic [5:0] page);
    logic [DATA_W-1:0] ok;
    for (int k = 0; k < DATA_W; k++) begin
      ok[k] = (int'(page) * DATA_W + k) < ROWS;
    end
    return ok;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(logic [5:0] page, logic [7:0] col);
    return ADDR_W'(int'(page) * COLUMNS + int'(col));
  endfunction

endpackage

>>> hw/rtl/page_packed_mono_framebuffer_top.sv
// monochrome page packed framebuffer, top level
// depends on ppmf_pkg, ppmf_ram, ppmf_ctrl, ppmf_obuf
//
// request channel: in_valid_i / in_stall_o with cmd_i, x_pos_i, y_pos_i,
// ink_i, column_bits_i, page_sel_i; a request is taken when valid is high
// and stall is low
// result channel: out_valid_o / out_stall_i with pixel_byte_o, byte_page_o,
// byte_column_o; only a read byte request gives a result
// the frame is one 512 x 8 ram with a registered read
// a pixel request reads then writes its page byte, and a glyph column does
// so for each page byte it touches (one extra read and write when it spans
// two pages with rows on screen); a read byte request passes the ram read
// register and then the output register, which shows the result
// a clear request sweeps the ram one byte a cycle, all 512 bytes
// after reset the same clearing pass runs with in_stall_o high
// a stalled result stays in the output register; the block keeps taking
// requests until a second read result would have to wait behind it

module page_packed_mono_framebuffer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic       ink_i,
  input  logic [6:0] column_bits_i,
  input  logic [1:0] page_sel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pixel_byte_o,
  output logic [1:0] byte_page_o,
  output logic [6:0] byte_column_o
);

  logic                         ram_we;
  logic [ppmf_pkg::ADDR_W-1:0]  ram_waddr;
  logic [ppmf_pkg::DATA_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [ppmf_pkg::ADDR_W-1:0]  ram_raddr;
  logic [ppmf_pkg::DATA_W-1:0]  ram_rdata;
  logic                         res_valid;
  logic                         res_ready;
  ppmf_pkg::result_t            res;

  ppmf_ram #(
    .Width(ppmf_pkg::DATA_W),
    .Depth(ppmf_pkg::STORE_SIZE)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ppmf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .ink_i         (ink_i),
    .column_bits_i (column_bits_i),
    .page_sel_i    (page_sel_i),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  ppmf_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .res_ready_o   (res_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_byte_o  (pixel_byte_o),
    .byte_page_o   (byte_page_o),
    .byte_column_o (byte_column_o)
  );

endmodule

>>> hw/rtl/ppmf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies

module ppmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ppmf_ctrl.sv
// command sequencer: read-modify-write of page bytes, clear sweep, byte read
// depends on ppmf_pkg

module ppmf_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic [7:0]                   x_pos_i,
  input  logic [7:0]                   y_pos_i,
  input  logic                         ink_i,
  input  logic [6:0]                   column_bits_i,
  input  logic [1:0]                   page_sel_i,
  output logic                         res_valid_o,
  output ppmf_pkg::result_t            res_o,
  input  logic                         res_ready_i,
  output logic                         ram_we_o,
  output logic [ppmf_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [ppmf_pkg::DATA_W-1:0]  ram_wdata_o,
  output logic                         ram_re_o,
  output logic [ppmf_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [ppmf_pkg::DATA_W-1:0]  ram_rdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR0,
    S_WR1,
    S_RDOUT
  } state_e;

  state_e                        state_q, state_d;
  logic [ppmf_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic [ppmf_pkg::ADDR_W-1:0]   addr0_q, addr0_d;
  logic [ppmf_pkg::ADDR_W-1:0]   addr1_q, addr1_d;
  logic [ppmf_pkg::DATA_W-1:0]   mask0_q, mask0_d;
  logic [ppmf_pkg::DATA_W-1:0]   mask1_q, mask1_d;
  logic                          ink_q, ink_d;
  logic                          rd_ok_q, rd_ok_d;
  logic [ppmf_pkg::PAGE_W-1:0]   page_q, page_d;
  logic [ppmf_pkg::COL_W-1:0]    col_q, col_d;

  ppmf_pkg::cmd_e                cmd;
  logic [ppmf_pkg::DATA_W-1:0]   pat;
  logic [2*ppmf_pkg::DATA_W-1:0] shifted;
  logic [5:0]                    page0, page1;
  logic                          col_ok;
  logic [ppmf_pkg::DATA_W-1:0]   cur_mask;

  assign cmd     = ppmf_pkg::cmd_e'(cmd_i);
  assign pat     = (cmd == ppmf_pkg::CMD_PIXEL) ? ppmf_pkg::DATA_W'(1)
                 : ({1'b0, column_bits_i} & ppmf_pkg::GLYPH_MASK);
  assign shifted = (2*ppmf_pkg::DATA_W)'(pat) << y_pos_i[2:0];
  assign page0   = {1'b0, y_pos_i[7:3]};
  assign page1   = page0 + 6'd1;
  assign col_ok  = {1'b0, x_pos_i} < 9'(ppmf_pkg::COLUMNS);
  assign cur_mask = (state_q == S_WR1) ? mask1_q : mask0_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr0_d     = addr0_q;
    addr1_d     = addr1_q;
    mask0_d     = mask0_q;
    mask1_d     = mask1_q;
    ink_d       = ink_q;
    rd_ok_d     = rd_ok_q;
    page_d      = page_q;
    col_d       = col_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr0_q;
    ram_wdata_o = ink_q ? (ram_rdata_i | cur_mask) : (ram_rdata_i & ~cur_mask);
    ram_re_o    = 1'b0;
    ram_raddr_o = addr1_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == ppmf_pkg::ADDR_W'(ppmf_pkg::STORE_SIZE - 1)) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (cmd)
            ppmf_pkg::CMD_PIXEL, ppmf_pkg::CMD_GLYPH: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = ppmf_pkg::byte_addr(page0, x_pos_i);
              addr0_d     = ppmf_pkg::byte_addr(page0, x_pos_i);
              addr1_d     = ppmf_pkg::byte_addr(page1, x_pos_i);
              mask0_d     = col_ok ? (shifted[ppmf_pkg::DATA_W-1:0] & ppmf_pkg::row_ok(page0))
                                   : '0;
              mask1_d     = col_ok ? (shifted[2*ppmf_pkg::DATA_W-1:ppmf_pkg::DATA_W]
                                      & ppmf_pkg::row_ok(page1)) : '0;
              ink_d       = ink_i;
              state_d     = S_WR0;
            end
            ppmf_pkg::CMD_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            ppmf_pkg::CMD_READ: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = ppmf_pkg::byte_addr({4'b0, page_sel_i}, x_pos_i);
              rd_ok_d     = col_ok && (int'(page_sel_i) < ppmf_pkg::PAGES);
              page_d      = page_sel_i;
              col_d       = x_pos_i[ppmf_pkg::COL_W-1:0];
              state_d     = S_RDOUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WR0: begin
        ram_we_o    = mask0_q != '0;
        ram_waddr_o = addr0_q;
        if (mask1_q != '0) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = addr1_q;
          state_d     = S_WR1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WR1: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr1_q;
        state_d     = S_IDLE;
      end
      S_RDOUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.pixel_byte  = rd_ok_q ? ram_rdata_i : '0;
  assign res_o.byte_page   = page_q;
  assign res_o.byte_column = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr0_q <= addr0_d;
    addr1_q <= addr1_d;
    mask0_q <= mask0_d;
    mask1_q <= mask1_d;
    ink_q   <= ink_d;
    rd_ok_q <= rd_ok_d;
    page_q  <= page_d;
    col_q   <= col_d;
  end

  // no read may target the byte being written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o)
    else $error("ram read and write hit the same byte");

  a_wr1_after_wr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR1 |-> $past(state_q) == S_WR0)
    else $error("second page write without first");

  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("read result lost while waiting");

endmodule

>>> hw/rtl/ppmf_obuf.sv
// one-entry output register for read results, parts the link side stall
// depends on ppmf_pkg

module ppmf_obuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        res_valid_i,
  input  ppmf_pkg::result_t           res_i,
  output logic                        res_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ppmf_pkg::DATA_W-1:0] pixel_byte_o,
  output logic [ppmf_pkg::PAGE_W-1:0] byte_page_o,
  output logic [ppmf_pkg::COL_W-1:0]  byte_column_o
);

  logic              valid_q, valid_d;
  ppmf_pkg::result_t data_q;

  assign res_ready_o = !valid_q || !out_stall_i;
  assign valid_d     = res_ready_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign pixel_byte_o  = data_q.pixel_byte;
  assign byte_page_o   = data_q.byte_page;
  assign byte_column_o = data_q.byte_column;

endmodule
